FILE: design/asbd_pkg.sv
`timescale 1ns / 1ps

package asbd_pkg;

  localparam logic [31:0] AddrTimerOneCtrl  = 32'he000_8004;
  localparam logic [31:0] AddrTimerOneCount = 32'he000_8008;
  localparam logic [31:0] AddrTickCtrl      = 32'he000_e010;
  localparam logic [31:0] AddrTickReload    = 32'he000_e014;
  localparam logic [31:0] AddrTickCount     = 32'he000_e018;
  localparam logic [31:0] AddrTickCalib     = 32'he000_e01c;
  localparam logic [31:0] AddrAccelCtrl     = 32'he01f_c000;
  localparam logic [31:0] AddrAccelId       = 32'he01f_c100;
  localparam logic [3:0]  SysRangeTop       = 4'he;

  localparam logic [16:0] TickCtrlMask   = 17'h1_0007;
  localparam int unsigned TickFlagBit    = 16;
  localparam int unsigned TickEnableBit  = 0;
  localparam logic [31:0] AccelIdValue   = 32'h0000_0001;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2,
    SIZE_WIDE = 2'd3
  } size_t;

  typedef enum logic [1:0] {
    CART_NONE  = 2'd0,
    CART_GRANT = 2'd1,
    CART_FAULT = 2'd2,
    CART_OTHER = 2'd3
  } cart_t;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  size_code;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [1:0]  cart_status;
    logic [31:0] cart_data;
  } access_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        fault;
  } result_t;

  typedef struct packed {
    logic [31:0] timer_one_control;
    logic [31:0] timer_one_count;
    logic [16:0] tick_control;
    logic [23:0] tick_reload;
    logic [23:0] tick_count;
    logic [23:0] tick_calibration;
    logic [31:0] accel_control;
  } regs_t;

endpackage

FILE: design/asbd_decode.sv
`timescale 1ns / 1ps

module asbd_decode (
  input  asbd_pkg::access_t acc,
  input  asbd_pkg::regs_t   regs,
  output asbd_pkg::result_t res,
  output asbd_pkg::regs_t   regs_next
);

  logic misaligned;
  logic rd_hit;
  logic [31:0] rd_word;

  always_comb begin
    case (asbd_pkg::size_t'(acc.size_code))
      asbd_pkg::SIZE_BYTE: misaligned = 1'b0;
      asbd_pkg::SIZE_HALF: misaligned = acc.address[0];
      default:             misaligned = (acc.address[1:0] != 2'b00);
    endcase
  end

  always_comb begin
    rd_hit  = 1'b1;
    rd_word = '0;
    case (acc.address)
      asbd_pkg::AddrTimerOneCtrl:  rd_word = regs.timer_one_control;
      asbd_pkg::AddrTimerOneCount: rd_word = regs.timer_one_count;
      asbd_pkg::AddrTickCtrl:      rd_word = {15'd0, regs.tick_control};
      asbd_pkg::AddrTickReload:    rd_word = {8'd0, regs.tick_reload};
      asbd_pkg::AddrTickCount:     rd_word = {8'd0, regs.tick_count};
      asbd_pkg::AddrTickCalib:     rd_word = {8'd0, regs.tick_calibration};
      asbd_pkg::AddrAccelCtrl:     rd_word = regs.accel_control;
      asbd_pkg::AddrAccelId:       rd_word = asbd_pkg::AccelIdValue;
      default:                     rd_hit  = 1'b0;
    endcase
  end

  always_comb begin
    regs_next     = regs;
    res.read_data = '0;
    res.fault     = 1'b0;
    if (misaligned) begin
      res.fault = 1'b1;
    end else if (acc.cart_status == asbd_pkg::CART_GRANT) begin
      if (!acc.req_type) begin
        res.read_data = acc.cart_data;
      end
    end else if (acc.cart_status == asbd_pkg::CART_FAULT) begin
      res.fault = 1'b1;
    end else if (acc.req_type) begin
      // every mapped register sits inside the ignored system range
      res.fault = (acc.address[31:28] != asbd_pkg::SysRangeTop);
      case (acc.address)
        asbd_pkg::AddrTimerOneCtrl:  regs_next.timer_one_control = acc.write_data;
        asbd_pkg::AddrTimerOneCount: regs_next.timer_one_count = acc.write_data;
        asbd_pkg::AddrTickCtrl: begin
          // rising enable reloads the counter
          if (!regs.tick_control[asbd_pkg::TickEnableBit] &&
              acc.write_data[asbd_pkg::TickEnableBit]) begin
            regs_next.tick_count = regs.tick_reload;
          end
          regs_next.tick_control = acc.write_data[16:0] & asbd_pkg::TickCtrlMask;
        end
        asbd_pkg::AddrTickReload:    regs_next.tick_reload = acc.write_data[23:0];
        asbd_pkg::AddrTickCount:     regs_next.tick_count = acc.write_data[23:0];
        asbd_pkg::AddrTickCalib:     regs_next.tick_calibration = acc.write_data[23:0];
        asbd_pkg::AddrAccelCtrl:     regs_next.accel_control = acc.write_data;
        default: ;
      endcase
    end else begin
      res.fault = !rd_hit;
      if (rd_hit) begin
        res.read_data = rd_word;
      end
      if (acc.address == asbd_pkg::AddrTickCtrl) begin
        regs_next.tick_control[asbd_pkg::TickFlagBit] = 1'b0;
      end
    end
  end

endmodule

FILE: design/arm_sysreg_bus_decoder_top.sv
`timescale 1ns / 1ps
// Each accepted word is decoded from the input register and registered as a result word.
// Throughput: one word per cycle unless out_stall holds a valid result; the input register
// and result register form a two-stage pipeline, and registers update as a word enters
// the result stage. Reset (synchronous, active high) empties both stages and clears all
// timer, SysTick and accelerator registers to zero.

module arm_sysreg_bus_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [1:0]  size_code,
  input  logic [31:0] address,
  input  logic [31:0] write_data,
  input  logic [1:0]  cart_status,
  input  logic [31:0] cart_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic        fault
);

  logic              s1_valid;
  asbd_pkg::access_t s1_acc;
  asbd_pkg::regs_t   regs;
  asbd_pkg::regs_t   regs_next;
  asbd_pkg::result_t res_next;
  asbd_pkg::result_t res;
  logic              out_free;
  logic              s1_move;
  logic              in_take;

  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  asbd_decode u_decode (
    .acc       (s1_acc),
    .regs      (regs),
    .res       (res_next),
    .regs_next (regs_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_acc <= '{req_type:    req_type,
                  size_code:   size_code,
                  address:     address,
                  write_data:  write_data,
                  cart_status: cart_status,
                  cart_data:   cart_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (s1_move) begin
      regs <= regs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res <= res_next;
    end
  end

  assign read_data = res.read_data;
  assign fault     = res.fault;

endmodule
